// File: sv/vrce_pkg.sv
// Package for the version reference-count engine.
// Holds the transaction structs, operation codes and field widths.
// Depends on nothing; the top level and the slot table refer to it by scoped names.
`default_nettype none

package vrce_pkg;

  localparam int ID_W   = 10;
  localparam int SLOT_W = 4;
  localparam int ACQ_W  = 24;
  localparam int BAL_W  = 32;

  // Function codes of an input transaction.
  localparam logic [1:0] FUNC_INIT     = 2'd0;
  localparam logic [1:0] FUNC_ACQUIRE  = 2'd1;
  localparam logic [1:0] FUNC_RELEASE  = 2'd2;
  localparam logic [1:0] FUNC_EXCHANGE = 2'd3;

  typedef struct packed {
    logic [1:0]        func;
    logic              conditional;
    logic [SLOT_W-1:0] slot_index;
    logic [ID_W-1:0]   version_id;
    logic              version_is_null;
    logic [ID_W-1:0]   expected_id;
    logic              expected_is_null;
  } in_item_t;

  typedef struct packed {
    logic            got_valid;
    logic [ID_W-1:0] got_id;
    logic            freed;
    logic [ID_W-1:0] freed_id;
    logic            swap_done;
  } out_item_t;

  // Work left for the balance stage after the slot stage.
  typedef enum logic [1:0] {
    BAL_NONE  = 2'd0,
    BAL_CLEAR = 2'd1,
    BAL_INC   = 2'd2,
    BAL_FOLD  = 2'd3
  } bal_op_t;

  typedef struct packed {
    logic             valid;
    bal_op_t          op;
    logic [ID_W-1:0]  id;
    logic [ACQ_W-1:0] acq;
    logic             got_valid;
    logic [ID_W-1:0]  got_id;
    logic             swap_done;
  } bal_cmd_t;

endpackage

`default_nettype wire

// File: sv/version_refcount_engine_unit.sv
// Top level of the version reference-count engine (split reference counting).
// Depends on vrce_pkg, vrce_slot_table and vrce_ram.
//
//   Channel  Ports                       Direction  Handshake
//   input    start, busy, in_item        in         start && !busy
//   result   out_valid, out_item         out        out_valid, one cycle
//
// A new transaction is accepted in every cycle; busy is always low.
// Each transaction yields exactly one result transaction. The slot stage
// works from the input register and issues the read of the balance memory;
// the registered read lines up with the command register, from which the
// balance stage works; the result register then drives the result ports.
// The receiver cannot stall, so nothing in the block ever waits.
// Reset is synchronous and active low. It clears the slot occupancy and the
// acquire counts at once; the balance memory is not cleared and holds
// meaningful data for a version only after an init transaction has written it.
`default_nettype none

module version_refcount_engine_unit #(
  parameter int NUM_SLOTS    = 16,
  parameter int NUM_VERSIONS = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire vrce_pkg::in_item_t in_item,
  output logic                    out_valid,
  output vrce_pkg::out_item_t     out_item
);

  localparam int VER_AW = $clog2(NUM_VERSIONS);

  // The pipeline has no structural hazard, so it never pushes back.
  assign busy = 1'b0;

  // Input register.
  logic               in_valid_r;
  vrce_pkg::in_item_t in_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_r <= in_item;
    end
  end

  // Slot stage: every slot update completes here, so the next transaction
  // always sees the current slot contents without any forwarding.
  vrce_pkg::bal_cmd_t cmd;
  vrce_pkg::bal_cmd_t cmd_r;

  vrce_slot_table #(
    .NUM_SLOTS    (NUM_SLOTS),
    .NUM_VERSIONS (NUM_VERSIONS)
  ) u_slot_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_valid_r),
    .item       (in_r),
    .cmd        (cmd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r <= '0;
    end else begin
      cmd_r <= cmd;
    end
  end

  // Balance memory. The read is issued from the slot stage and its data
  // lines up with cmd_r in the balance stage.
  logic                       rd_en;
  logic [vrce_pkg::BAL_W-1:0] rd_data;
  logic                       wr_en;
  logic [vrce_pkg::BAL_W-1:0] bal_nxt;

  assign rd_en = cmd.valid && ((cmd.op == vrce_pkg::BAL_INC) ||
                               (cmd.op == vrce_pkg::BAL_FOLD));
  assign wr_en = cmd_r.valid && (cmd_r.op != vrce_pkg::BAL_NONE);

  vrce_ram #(
    .WIDTH (vrce_pkg::BAL_W),
    .DEPTH (NUM_VERSIONS)
  ) u_balance_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (VER_AW'(cmd_r.id)),
    .wdata (bal_nxt),
    .re    (rd_en),
    .raddr (VER_AW'(cmd.id)),
    .rdata (rd_data)
  );

  // The read in the slot stage happens in the same cycle as the write of the
  // transaction ahead of it, so that write is held in the forwarding registers
  // and forwarded when both touch the same version. Older writes are already
  // visible through the memory.
  logic                       fwd_valid_r;
  logic [vrce_pkg::ID_W-1:0]  fwd_id_r;
  logic [vrce_pkg::BAL_W-1:0] fwd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else begin
      fwd_valid_r <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_id_r   <= cmd_r.id;
      fwd_data_r <= bal_nxt;
    end
  end

  // Balance stage.
  logic [vrce_pkg::BAL_W-1:0] bal_cur;
  logic [vrce_pkg::ACQ_W:0]   fold_diff;
  logic                       fold_nz;
  logic                       freed;
  vrce_pkg::out_item_t        res;

  assign bal_cur = (fwd_valid_r && (fwd_id_r == cmd_r.id)) ? fwd_data_r : rd_data;

  // Low 24 bits of the balance minus the acquire count. A difference that is
  // positive means the acquire count wrapped, and it is taken down by a
  // further 2^24; after that, any non-zero value is negative, so the upper
  // bits are all copies of the non-zero flag.
  assign fold_diff = {1'b0, bal_cur[vrce_pkg::ACQ_W-1:0]} - {1'b0, cmd_r.acq};
  assign fold_nz   = (fold_diff != '0);

  always_comb begin
    bal_nxt = '0;
    freed   = 1'b0;
    case (cmd_r.op)
      vrce_pkg::BAL_CLEAR: begin
        bal_nxt = '0;
      end
      vrce_pkg::BAL_INC: begin
        bal_nxt = bal_cur + 1'b1;
        freed   = (bal_nxt == '0);
      end
      vrce_pkg::BAL_FOLD: begin
        bal_nxt = {{(vrce_pkg::BAL_W - vrce_pkg::ACQ_W){fold_nz}},
                   fold_diff[vrce_pkg::ACQ_W-1:0]};
        freed   = !fold_nz;
      end
      default: begin
        bal_nxt = '0;
        freed   = 1'b0;
      end
    endcase
  end

  always_comb begin
    res           = '0;
    res.got_valid = cmd_r.got_valid;
    res.got_id    = cmd_r.got_id;
    res.swap_done = cmd_r.swap_done;
    res.freed     = freed;
    res.freed_id  = freed ? cmd_r.id : '0;
  end

  // Result register: one strobed result transaction per accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_r.valid) begin
      out_item <= res;
    end
  end

endmodule

`default_nettype wire

// File: sv/vrce_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the per-version balance table; depends on nothing.
`default_nettype none

module vrce_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [AW-1:0]         waddr,
  input  wire logic [WIDTH-1:0]      wdata,
  input  wire logic                  re,
  input  wire logic [AW-1:0]         raddr,
  output logic      [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// File: sv/vrce_slot_table.sv
// Publication slot table: current version, occupancy and acquire count per slot.
// Performs the slot half of every operation and hands the balance work onward.
// Depends on vrce_pkg.
`default_nettype none

module vrce_slot_table #(
  parameter int NUM_SLOTS    = 16,
  parameter int NUM_VERSIONS = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              item_valid,
  input  wire vrce_pkg::in_item_t item,
  output vrce_pkg::bal_cmd_t     cmd
);

  localparam int SLOT_AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic [NUM_SLOTS-1:0]       occ_r;
  logic [vrce_pkg::ID_W-1:0]  ver_r [NUM_SLOTS];
  logic [vrce_pkg::ACQ_W-1:0] acq_r [NUM_SLOTS];

  logic                       slot_ok;
  logic                       ver_ok;
  logic                       match;
  logic [SLOT_AW-1:0]         sidx;
  logic                       occ_cur;
  logic [vrce_pkg::ID_W-1:0]  ver_cur;
  logic [vrce_pkg::ACQ_W-1:0] acq_cur;
  logic                       slot_we;
  logic                       occ_nxt;
  logic [vrce_pkg::ID_W-1:0]  ver_nxt;
  logic [vrce_pkg::ACQ_W-1:0] acq_nxt;

  assign slot_ok = 32'(item.slot_index) < NUM_SLOTS;
  assign ver_ok  = 32'(item.version_id) < NUM_VERSIONS;
  assign sidx    = SLOT_AW'(item.slot_index);
  assign occ_cur = occ_r[sidx];
  assign ver_cur = ver_r[sidx];
  assign acq_cur = acq_r[sidx];

  assign match = item.expected_is_null ? !occ_cur
                                       : (occ_cur && (ver_cur == item.expected_id));

  always_comb begin
    cmd       = '0;
    cmd.valid = item_valid;
    cmd.op    = vrce_pkg::BAL_NONE;
    cmd.id    = item.version_id;
    slot_we   = 1'b0;
    occ_nxt   = occ_cur;
    ver_nxt   = ver_cur;
    acq_nxt   = acq_cur;
    case (item.func)
      vrce_pkg::FUNC_INIT: begin
        if (ver_ok) begin
          cmd.op = vrce_pkg::BAL_CLEAR;
        end
      end
      vrce_pkg::FUNC_ACQUIRE: begin
        if (slot_ok) begin
          cmd.got_valid = occ_cur;
          cmd.got_id    = occ_cur ? ver_cur : '0;
          slot_we       = 1'b1;
          acq_nxt       = acq_cur + 1'b1;
        end
      end
      vrce_pkg::FUNC_RELEASE: begin
        if (ver_ok) begin
          cmd.op = vrce_pkg::BAL_INC;
        end
      end
      vrce_pkg::FUNC_EXCHANGE: begin
        if (slot_ok && (item.version_is_null || ver_ok) &&
            (!item.conditional || match)) begin
          cmd.swap_done = 1'b1;
          slot_we       = 1'b1;
          occ_nxt       = !item.version_is_null;
          ver_nxt       = item.version_is_null ? '0 : item.version_id;
          acq_nxt       = '0;
          if (occ_cur) begin
            // The outgoing version takes the acquires it collected here.
            cmd.op  = vrce_pkg::BAL_FOLD;
            cmd.id  = ver_cur;
            cmd.acq = acq_cur;
          end
        end
      end
      default: begin
        cmd.op = vrce_pkg::BAL_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        acq_r[i] <= '0;
      end
    end else if (item_valid && slot_we) begin
      occ_r[sidx] <= occ_nxt;
      acq_r[sidx] <= acq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && slot_we) begin
      ver_r[sidx] <= ver_nxt;
    end
  end

endmodule

`default_nettype wire
